// ===== src/tiaf_pkg.sv =====
// ----------------------------------------------------------------------------
// tiaf_pkg: shared types and constants of the incidence angle filter
// Beat layouts, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package tiaf_pkg;

    localparam int COORD_BITS = 24;
    localparam int COS_W      = 17;
    localparam int COS_FRAC   = 16;
    localparam int TAG_W      = 16;
    localparam int CFG_W      = (COORD_BITS > COS_W) ? COORD_BITS : COS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int LIMB_W     = 32;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [CFG_IDX_W-1:0]         t_cfg_idx;

    localparam t_cfg_idx REG_SENSOR_X      = 3'd0;
    localparam t_cfg_idx REG_SENSOR_Y      = 3'd1;
    localparam t_cfg_idx REG_SENSOR_Z      = 3'd2;
    localparam t_cfg_idx REG_THRESHOLD_COS = 3'd3;
    localparam t_cfg_idx REG_FILTER_ENABLE = 3'd4;

    typedef struct packed {
        t_coord             corner_a_x;
        t_coord             corner_a_y;
        t_coord             corner_a_z;
        t_coord             corner_b_x;
        t_coord             corner_b_y;
        t_coord             corner_b_z;
        t_coord             corner_c_x;
        t_coord             corner_c_y;
        t_coord             corner_c_z;
        logic [TAG_W-1:0]   triangle_tag;
    } t_tri;

    typedef struct packed {
        logic               drop;
        logic               degenerate;
        logic [TAG_W-1:0]   tag_out;
    } t_res;

endpackage

// ===== src/tiaf_mul.sv =====
// ----------------------------------------------------------------------------
// tiaf_mul: pipelined unsigned wide multiplier
// Limb partial products in one stage, then a registered binary adder tree.
// 2**LEVELS must cover all limb products.
// ----------------------------------------------------------------------------
module tiaf_mul #(
    parameter int WA     = 32,
    parameter int WB     = 32,
    parameter int LEVELS = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [WA-1:0]       i_a,
    input  logic [WB-1:0]       i_b,
    output logic [WA+WB-1:0]    o_p
);

    localparam int LW    = tiaf_pkg::LIMB_W;
    localparam int NA    = (WA + LW - 1) / LW;
    localparam int NB    = (WB + LW - 1) / LW;
    localparam int NPP   = NA * NB;
    localparam int NLEAF = 1 << LEVELS;
    localparam int NNODE = 2 * NLEAF - 1;
    localparam int WAP   = NA * LW;
    localparam int WBP   = NB * LW;
    localparam int WQ    = (NA + NB) * LW;

    logic [WAP-1:0] w_a;
    logic [WBP-1:0] w_b;
    logic [WQ-1:0]  w_pp [NLEAF];
    logic [WQ-1:0]  r_node [NNODE];

    assign w_a = WAP'(i_a);
    assign w_b = WBP'(i_b);

    always_comb begin
        logic [2*LW-1:0] v_prod;
        for (int k = 0; k < NLEAF; k++) begin
            if (k < NPP) begin
                v_prod  = w_a[(k / NB) * LW +: LW] * w_b[(k % NB) * LW +: LW];
                w_pp[k] = WQ'(v_prod) << (((k / NB) + (k % NB)) * LW);
            end else begin
                w_pp[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < NNODE; m++) begin
                if (m < NLEAF - 1) begin
                    r_node[m] <= r_node[2*m+1] + r_node[2*m+2];
                end else begin
                    r_node[m] <= w_pp[m - (NLEAF - 1)];
                end
            end
        end
    end

    assign o_p = r_node[0][WA+WB-1:0];

endmodule

// ===== src/triangle_incidence_angle_filter.sv =====
// ----------------------------------------------------------------------------
// triangle_incidence_angle_filter: jump face test for one mesh triangle
// Normal by cross product, ray to the sensor, exact squared cosine compare.
//
//   channel  | dir | handshake          | beat
//   ---------+-----+--------------------+-----------------------------
//   triangle | in  | i_valid / o_stall  | i_in  (t_tri)
//   result   | out | o_valid / i_stall  | o_res (t_res)
//   config   | in  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One triangle per cycle while o_stall is low; from accept to the result beat
// it runs through the chain of wide multiplier trees (dot products, squares, cosine).
// A two-entry output queue holds results; the pipeline stalls only when the
// queue is full and the last stage holds a result.
// Synchronous active-low reset clears the valids, the queue count and the config registers.
// ----------------------------------------------------------------------------
module triangle_incidence_angle_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  tiaf_pkg::t_tri              i_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output tiaf_pkg::t_res              o_res,
    input  logic                        i_cfg_we,
    input  tiaf_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [tiaf_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int C    = tiaf_pkg::COORD_BITS;
    localparam int LW   = tiaf_pkg::LIMB_W;
    localparam int WE   = C + 1;
    localparam int WS   = C + 3;
    localparam int WPC  = 2 * C + 1;
    localparam int WN   = 2 * C + 2;
    localparam int WNM  = 2 * C + 1;
    localparam int WSM  = C + 2;
    localparam int WNN  = 2 * WNM + 2;
    localparam int WSS  = 2 * WSM + 2;
    localparam int WT   = WNM + WSM + 1;
    localparam int WNS  = WT + 2;
    localparam int WNA  = WNM + WSM + 2;
    localparam int WSQ  = 2 * WNA;
    localparam int WP2  = WNN + WSS;
    localparam int WCS  = 2 * tiaf_pkg::COS_W;
    localparam int WP3  = WP2 + WCS;
    localparam int WLHS = WSQ + 2 * tiaf_pkg::COS_FRAC;
    localparam int WCMP = (WLHS > WP3) ? WLHS : WP3;

    localparam int NL_NM = (WNM + LW - 1) / LW;
    localparam int NL_NA = (WNA + LW - 1) / LW;
    localparam int NL_NN = (WNN + LW - 1) / LW;
    localparam int NL_SS = (WSS + LW - 1) / LW;
    localparam int NL_P2 = (WP2 + LW - 1) / LW;
    localparam int NL_CS = (WCS + LW - 1) / LW;

    localparam int LV1  = $clog2(NL_NM * NL_NM);
    localparam int LV2A = $clog2(NL_NA * NL_NA);
    localparam int LV2B = $clog2(NL_NN * NL_SS);
    localparam int LV2  = (LV2A > LV2B) ? LV2A : LV2B;
    localparam int LV3  = $clog2(NL_P2 * NL_CS);
    localparam int LAT1 = LV1 + 1;
    localparam int LAT2 = LV2 + 1;
    localparam int LAT3 = LV3 + 1;

    localparam int P1  = 4 + LAT1;
    localparam int PB  = P1 + 2;
    localparam int P3  = P1 + 3 + LAT2 + LAT3;
    localparam int DGN = P3 - PB + 1;

    // configuration
    tiaf_pkg::t_coord               r_org [3];
    logic [tiaf_pkg::COS_W-1:0]     r_cos;
    logic                           r_en;
    logic [WCS-1:0]                 r_cos_sq;

    // flow control
    logic                           w_adv;
    logic                           w_in_acc;
    logic [P3-1:0]                  r_vld;
    logic [tiaf_pkg::TAG_W-1:0]     r_tag [P3];
    logic                           r_dg [DGN];

    // datapath
    tiaf_pkg::t_coord               w_ca [3];
    tiaf_pkg::t_coord               w_cb [3];
    tiaf_pkg::t_coord               w_cc [3];
    logic signed [WE-1:0]           n_e1 [3];
    logic signed [WE-1:0]           n_e2 [3];
    logic signed [WS-1:0]           n_s [3];
    logic signed [WE-1:0]           r_e1 [3];
    logic signed [WE-1:0]           r_e2 [3];
    logic signed [WS-1:0]           r_s [3];
    logic signed [WS-1:0]           r_s2 [3];
    logic signed [WS-1:0]           r_s3 [3];
    logic signed [WPC-1:0]          r_pc [6];
    logic signed [WN-1:0]           r_n [3];
    logic [WNM-1:0]                 r_nm [3];
    logic [WSM-1:0]                 r_sm [3];
    logic [2:0]                     r_tsg [LAT1+1];
    logic [2*WNM-1:0]               w_nnp [3];
    logic [2*WSM-1:0]               w_ssp [3];
    logic [WNM+WSM-1:0]             w_nsp [3];
    logic [WNN-1:0]                 r_nn;
    logic [WSS-1:0]                 r_ss;
    logic signed [WT-1:0]           r_t [3];
    logic signed [WNS-1:0]          r_ns;
    logic [WNN-1:0]                 r_nn_b;
    logic [WSS-1:0]                 r_ss_b;
    logic [WNA-1:0]                 r_na;
    logic [WNN-1:0]                 r_nn_c;
    logic [WSS-1:0]                 r_ss_c;
    logic [WSQ-1:0]                 w_sq;
    logic [WP2-1:0]                 w_p2;
    logic [WP3-1:0]                 w_p3;
    logic [WSQ-1:0]                 r_sq_d [LAT3];
    logic [WCMP-1:0]                w_lhs;
    logic [WCMP-1:0]                w_rhs;
    logic                           w_drop;

    // final stage and output queue
    tiaf_pkg::t_res                 r_fin;
    logic                           r_fin_vld;
    tiaf_pkg::t_res                 r_q [2];
    logic [1:0]                     r_cnt;
    logic                           w_push;
    logic                           w_pop;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_cos    <= '0;
            r_en     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tiaf_pkg::REG_SENSOR_X:      r_org[0] <= i_cfg_data[C-1:0];
                tiaf_pkg::REG_SENSOR_Y:      r_org[1] <= i_cfg_data[C-1:0];
                tiaf_pkg::REG_SENSOR_Z:      r_org[2] <= i_cfg_data[C-1:0];
                tiaf_pkg::REG_THRESHOLD_COS: r_cos <= i_cfg_data[tiaf_pkg::COS_W-1:0];
                tiaf_pkg::REG_FILTER_ENABLE: r_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos_sq <= r_cos * r_cos;
    end

    // ---------------- flow control ----------------
    assign w_adv    = !r_fin_vld || (r_cnt != 2'd2);
    assign w_in_acc = i_valid && w_adv;
    assign o_stall  = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fin_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[P3-2:0], w_in_acc};
            r_fin_vld <= r_vld[P3-1];
        end
    end

    // ---------------- stage 1: edges and ray ----------------
    assign w_ca[0] = i_in.corner_a_x;
    assign w_ca[1] = i_in.corner_a_y;
    assign w_ca[2] = i_in.corner_a_z;
    assign w_cb[0] = i_in.corner_b_x;
    assign w_cb[1] = i_in.corner_b_y;
    assign w_cb[2] = i_in.corner_b_z;
    assign w_cc[0] = i_in.corner_c_x;
    assign w_cc[1] = i_in.corner_c_y;
    assign w_cc[2] = i_in.corner_c_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_e1[k] = WE'(w_cb[k]) - WE'(w_ca[k]);
            n_e2[k] = WE'(w_cc[k]) - WE'(w_ca[k]);
            n_s[k]  = (WS'(r_org[k]) + WS'(r_org[k]) + WS'(r_org[k]))
                    - (WS'(w_ca[k]) + WS'(w_cb[k]) + WS'(w_cc[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= n_e1[k];
                r_e2[k] <= n_e2[k];
                r_s[k]  <= n_s[k];
                r_s2[k] <= r_s[k];
                r_s3[k] <= r_s2[k];
            end
            r_tag[0] <= i_in.triangle_tag;
            for (int k = 1; k < P3; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // ---------------- stages 2 to 4: normal and magnitudes ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pc[0] <= r_e1[1] * r_e2[2];
            r_pc[1] <= r_e1[2] * r_e2[1];
            r_pc[2] <= r_e1[2] * r_e2[0];
            r_pc[3] <= r_e1[0] * r_e2[2];
            r_pc[4] <= r_e1[0] * r_e2[1];
            r_pc[5] <= r_e1[1] * r_e2[0];

            r_n[0] <= WN'(r_pc[0]) - WN'(r_pc[1]);
            r_n[1] <= WN'(r_pc[2]) - WN'(r_pc[3]);
            r_n[2] <= WN'(r_pc[4]) - WN'(r_pc[5]);

            for (int k = 0; k < 3; k++) begin
                r_nm[k]     <= r_n[k][WN-1] ? WNM'(-r_n[k]) : WNM'(r_n[k]);
                r_sm[k]     <= r_s3[k][WS-1] ? WSM'(-r_s3[k]) : WSM'(r_s3[k]);
                r_tsg[0][k] <= r_n[k][WN-1] ^ r_s3[k][WS-1];
            end
            for (int k = 1; k <= LAT1; k++) begin
                r_tsg[k] <= r_tsg[k-1];
            end
        end
    end

    // ---------------- squares and dot product terms ----------------
    for (genvar g = 0; g < 3; g++) begin : g_dot
        tiaf_mul #(.WA(WNM), .WB(WNM), .LEVELS(LV1)) u_nn (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (r_nm[g]),
            .i_b   (r_nm[g]),
            .o_p   (w_nnp[g])
        );
        tiaf_mul #(.WA(WSM), .WB(WSM), .LEVELS(LV1)) u_ss (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (r_sm[g]),
            .i_b   (r_sm[g]),
            .o_p   (w_ssp[g])
        );
        tiaf_mul #(.WA(WNM), .WB(WSM), .LEVELS(LV1)) u_ns (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (r_nm[g]),
            .i_b   (r_sm[g]),
            .o_p   (w_nsp[g])
        );
    end

    // ---------------- sums, degenerate flag, |n.s| ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nn <= WNN'(w_nnp[0]) + WNN'(w_nnp[1]) + WNN'(w_nnp[2]);
            r_ss <= WSS'(w_ssp[0]) + WSS'(w_ssp[1]) + WSS'(w_ssp[2]);
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= r_tsg[LAT1][k] ? -WT'(w_nsp[k]) : WT'(w_nsp[k]);
            end

            r_ns   <= WNS'(r_t[0]) + WNS'(r_t[1]) + WNS'(r_t[2]);
            r_nn_b <= r_nn;
            r_ss_b <= r_ss;
            r_dg[0] <= (r_nn == '0) || (r_ss == '0);
            for (int k = 1; k < DGN; k++) begin
                r_dg[k] <= r_dg[k-1];
            end

            r_na   <= r_ns[WNS-1] ? WNA'(-r_ns) : WNA'(r_ns);
            r_nn_c <= r_nn_b;
            r_ss_c <= r_ss_b;
        end
    end

    // ---------------- (n.s)^2 and |n|^2 |s|^2 cos^2 ----------------
    tiaf_mul #(.WA(WNA), .WB(WNA), .LEVELS(LV2)) u_sq (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r_na),
        .i_b   (r_na),
        .o_p   (w_sq)
    );

    tiaf_mul #(.WA(WNN), .WB(WSS), .LEVELS(LV2)) u_p2 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r_nn_c),
        .i_b   (r_ss_c),
        .o_p   (w_p2)
    );

    tiaf_mul #(.WA(WP2), .WB(WCS), .LEVELS(LV3)) u_p3 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (w_p2),
        .i_b   (r_cos_sq),
        .o_p   (w_p3)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_d[0] <= w_sq;
            for (int k = 1; k < LAT3; k++) begin
                r_sq_d[k] <= r_sq_d[k-1];
            end
        end
    end

    // ---------------- compare ----------------
    assign w_lhs  = WCMP'(r_sq_d[LAT3-1]) << (2 * tiaf_pkg::COS_FRAC);
    assign w_rhs  = WCMP'(w_p3);
    assign w_drop = r_en && !r_dg[DGN-1] && (w_lhs <= w_rhs);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin.drop       <= w_drop;
            r_fin.degenerate <= r_dg[DGN-1];
            r_fin.tag_out    <= r_tag[P3-1];
        end
    end

    // ---------------- output queue ----------------
    assign w_push = r_fin_vld && w_adv;
    assign w_pop  = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_q[0] <= (r_cnt == 2'd2) ? r_q[1] : r_fin;
        end else if (w_push) begin
            r_q[r_cnt[0]] <= r_fin;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q[0];

    // ---------------- assertions ----------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue overflow");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_vld && !w_adv) |=> (r_fin_vld && $stable(r_fin)))
        else $error("last stage lost a beat while frozen");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_cnt == 2'd2 && r_fin_vld))
        else $error("input stalled without a full queue");

    a_drop_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_res.drop && o_res.degenerate))
        else $error("degenerate triangle dropped");

    a_drop_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.drop) |-> r_en)
        else $error("drop while filter disabled");

endmodule
